/* hw/rtl/fbdiv_pkg.sv */
// fbdiv_pkg: fixed field widths, scale constants and status codes for the
// fractional baud divisor search. No dependencies.
package fbdiv_pkg;

   localparam int BAUD_W   = 28;
   localparam int CLK_W    = 32;
   localparam int ERR_W    = 32;
   localparam int STATUS_W = 2;

   // achieved rate is reported times 1000
   localparam int RATE_SCALE = 1000;
   localparam int RATE_W     = 10;
   // achieved*1000 never exceeds clk*1000/16, so it fits in clk width + 6 bits
   localparam int ACH_W      = CLK_W + 6;

   localparam logic [ERR_W-1:0] ERR_LIMIT = '1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RATE_HIGH = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_PAIR   = 2'd2;

   typedef logic [STATUS_W-1:0] status_type;

endpackage

/* hw/rtl/fbdiv_sub_step.sv */
// fbdiv_sub_step: one restoring-division step (shift in a bit, compare,
// conditionally subtract). Shared by both divisions. Imports fbdiv_pkg.
module fbdiv_sub_step
   import fbdiv_pkg::*;
#(
   parameter int W = 32
) (
   input  logic [W-1:0] rem,
   input  logic         num_bit,
   input  logic [W-1:0] divisor,
   output logic         ge,
   output logic [W-1:0] rem_next
);

   logic [W:0] trial;
   logic [W:0] diff;

   assign trial    = {rem, num_bit};
   assign diff     = trial - {1'b0, divisor};
   assign ge       = (trial >= {1'b0, divisor});
   assign rem_next = ge ? diff[W-1:0] : trial[W-1:0];

endmodule

/* hw/rtl/fractional_baud_divisor_search.sv */
// fractional_baud_divisor_search: searches trial divisors 1..MAX_RELOAD_STEPS (reported
// reload = divisor - 1) for the best fractional divider; depends on fbdiv_pkg and fbdiv_sub_step.
// A rate-too-high request goes straight to the finish state; otherwise each trial runs the
//   overflow check, the fdv division, the range check, the multiply states, the rate division
//   and the compare. A trial whose fdv leaves range ends the search.
// One request at a time; req_stall is high while the sequencer is busy. Reset (synchronous):
//   sequencer idle, no response pending, clock register = 100 MHz.
module fractional_baud_divisor_search
   import fbdiv_pkg::*;
#(
   parameter int MAX_RELOAD_STEPS    = 8192,
   parameter int FRACTION_FULL_SCALE = 512
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // config
   input  logic                                     csr_wr_en,
   input  logic [CLK_W-1:0]                         csr_wr_data,
   // request
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [BAUD_W-1:0]                        req_baud_rate,
   // response
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [$clog2(FRACTION_FULL_SCALE)-1:0]   rsp_divider_fraction,
   output logic [$clog2(MAX_RELOAD_STEPS)-1:0]      rsp_reload_value,
   output logic [ERR_W-1:0]                         rsp_rate_error,
   output logic [STATUS_W-1:0]                      rsp_status
);

   // ---------------------------------------------------------------------
   // Derived widths
   // ---------------------------------------------------------------------
   localparam int FW    = $clog2(FRACTION_FULL_SCALE);  // reported fraction
   localparam int QW    = FW + 1;                       // fdv quotient, holds full scale
   localparam int RW    = $clog2(MAX_RELOAD_STEPS);     // reported reload
   localparam int BGW   = $clog2(MAX_RELOAD_STEPS + 1); // trial divisor 1..MAX
   localparam int SCALE = 16 * FRACTION_FULL_SCALE;
   localparam int SCW   = $clog2(SCALE + 1);
   localparam int STW   = BAUD_W + SCW;                 // baud*16*FULL
   localparam int NW    = STW + BGW + 1;                // baud*16*FULL*bg + clk/2
   localparam int DENW  = SCW + BGW;                    // 16*FULL*bg
   localparam int DW    = (DENW > CLK_W) ? DENW : CLK_W;
   localparam int P1W   = QW + CLK_W;                   // fdv*clk
   localparam int P2W   = P1W + RATE_W;                 // fdv*clk*1000
   localparam int TW    = BAUD_W + RATE_W;              // baud*1000
   localparam int EW    = (ACH_W > TW) ? ACH_W : TW;
   localparam int SHW   = (ACH_W > QW) ? ACH_W : QW;
   localparam int CW    = $clog2(SHW + 1);

   // sequencer codes
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CHK    = 4'd1;  // fdv overflow check (first step)
   localparam logic [3:0] ST_DIV1   = 4'd2;  // fdv = N / clk
   localparam logic [3:0] ST_FCHK   = 4'd3;  // fdv <= full scale?
   localparam logic [3:0] ST_MUL1   = 4'd4;  // fdv*clk
   localparam logic [3:0] ST_MUL2   = 4'd5;  // *1000, load second division
   localparam logic [3:0] ST_DIV2   = 4'd6;  // achieved = P / (16*FULL*bg)
   localparam logic [3:0] ST_ERR    = 4'd7;  // error, keep best, advance bg
   localparam logic [3:0] ST_FINISH = 4'd8;  // post response

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   logic [3:0]        state_ff, state_in;
   logic [CLK_W-1:0]  clk_ff, clk_in;
   logic [STW-1:0]    step_ff, step_in;
   logic [TW-1:0]     target_ff, target_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [DENW-1:0]   den_ff, den_in;
   logic [BGW-1:0]    bg_ff, bg_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [SHW-1:0]    sh_ff, sh_in;
   logic [SHW-1:0]    q_ff, q_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [QW-1:0]     fdv_ff, fdv_in;
   logic [P1W-1:0]    prod_ff, prod_in;
   logic [ERR_W-1:0]  best_err_ff, best_err_in;
   logic [FW-1:0]     best_fdv_ff, best_fdv_in;
   logic [RW-1:0]     best_reload_ff, best_reload_in;
   logic              found_ff, found_in;
   logic              high_ff, high_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]     rsp_frac_ff, rsp_frac_in;
   logic [RW-1:0]     rsp_reload_ff, rsp_reload_in;
   logic [ERR_W-1:0]  rsp_err_ff, rsp_err_in;
   status_type        rsp_status_ff, rsp_status_in;

   // ---------------------------------------------------------------------
   // Shared compare/subtract step
   // ---------------------------------------------------------------------
   logic [DW-1:0] unit_rem, unit_div, unit_rem_next;
   logic          unit_bit, unit_ge;

   always_comb begin
      case (state_ff)
         ST_CHK: begin
            // first step of N/clk: any quotient bit at 2^QW or above means fdv too big
            unit_rem = DW'(n_ff[QW+CLK_W-1:QW+1]);
            unit_bit = n_ff[QW];
            unit_div = DW'(clk_ff);
         end
         ST_DIV1: begin
            unit_rem = rem_ff;
            unit_bit = sh_ff[SHW-1];
            unit_div = DW'(clk_ff);
         end
         default: begin
            unit_rem = rem_ff;
            unit_bit = sh_ff[SHW-1];
            unit_div = DW'(den_ff);
         end
      endcase
   end

   fbdiv_sub_step #(
      .W (DW)
   ) u_step (
      .rem      (unit_rem),
      .num_bit  (unit_bit),
      .divisor  (unit_div),
      .ge       (unit_ge),
      .rem_next (unit_rem_next)
   );

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   logic            req_accept;
   logic            rsp_accept;
   logic [STW-1:0]  step_new;
   logic [P2W-1:0]  prod2;
   logic [EW-1:0]   achieved;
   logic [EW-1:0]   err;
   logic [BGW-1:0]  bg_minus;
   logic            n_upper;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;

   assign step_new = STW'(req_baud_rate) * STW'(SCALE);
   assign prod2    = P2W'(prod_ff) * P2W'(RATE_SCALE);
   assign achieved = EW'(q_ff[ACH_W-1:0]);
   assign err      = (achieved >= EW'(target_ff)) ? (achieved - EW'(target_ff))
                                                  : (EW'(target_ff) - achieved);
   assign bg_minus = bg_ff - BGW'(1);
   assign n_upper  = |n_ff[NW-1:QW+CLK_W];

   always_comb begin
      state_in       = state_ff;
      clk_in         = clk_ff;
      step_in        = step_ff;
      target_in      = target_ff;
      n_in           = n_ff;
      den_in         = den_ff;
      bg_in          = bg_ff;
      rem_in         = rem_ff;
      sh_in          = sh_ff;
      q_in           = q_ff;
      cnt_in         = cnt_ff;
      fdv_in         = fdv_ff;
      prod_in        = prod_ff;
      best_err_in    = best_err_ff;
      best_fdv_in    = best_fdv_ff;
      best_reload_in = best_reload_ff;
      found_in       = found_ff;
      high_in        = high_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_frac_in    = rsp_frac_ff;
      rsp_reload_in  = rsp_reload_ff;
      rsp_err_in     = rsp_err_ff;
      rsp_status_in  = rsp_status_ff;

      if (csr_wr_en) begin
         clk_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               step_in     = step_new;
               target_in   = TW'(req_baud_rate) * TW'(RATE_SCALE);
               n_in        = NW'(step_new) + NW'(clk_ff[CLK_W-1:1]);
               den_in      = DENW'(SCALE);
               bg_in       = BGW'(1);
               best_err_in = ERR_LIMIT;
               found_in    = 1'b0;
               // rate must stay below clk/16; also covers clk < 16
               high_in     = (req_baud_rate >= clk_ff[CLK_W-1:4]);
               state_in    = (req_baud_rate >= clk_ff[CLK_W-1:4]) ? ST_FINISH : ST_CHK;
            end
         end
         ST_CHK: begin
            // fdv only grows with bg, so once it overflows the search is over
            if (n_upper || unit_ge) begin
               state_in = ST_FINISH;
            end else begin
               rem_in   = unit_rem_next;
               sh_in    = SHW'(n_ff[QW-1:0]) << (SHW - QW);
               q_in     = '0;
               cnt_in   = CW'(QW);
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            rem_in = unit_rem_next;
            sh_in  = sh_ff << 1;
            q_in   = {q_ff[SHW-2:0], unit_ge};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = ST_FCHK;
            end
         end
         ST_FCHK: begin
            if (q_ff[QW-1:0] > QW'(FRACTION_FULL_SCALE)) begin
               state_in = ST_FINISH;
            end else begin
               fdv_in   = q_ff[QW-1:0];
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            prod_in  = P1W'(fdv_ff) * P1W'(clk_ff);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            // achieved < 2^ACH_W, so the top part is already below the divisor
            rem_in   = DW'(prod2[P2W-1:ACH_W]);
            sh_in    = SHW'(prod2[ACH_W-1:0]) << (SHW - ACH_W);
            q_in     = '0;
            cnt_in   = CW'(ACH_W);
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            rem_in = unit_rem_next;
            sh_in  = sh_ff << 1;
            q_in   = {q_ff[SHW-2:0], unit_ge};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            if (err < EW'(best_err_ff)) begin
               best_err_in    = err[ERR_W-1:0];
               best_fdv_in    = fdv_ff[FW-1:0];
               best_reload_in = bg_minus[RW-1:0];
               found_in       = 1'b1;
            end
            // exact hit ends the search early
            if ((err == '0) || (bg_ff == BGW'(MAX_RELOAD_STEPS))) begin
               state_in = ST_FINISH;
            end else begin
               bg_in    = bg_ff + BGW'(1);
               n_in     = n_ff + NW'(step_ff);
               den_in   = den_ff + DENW'(SCALE);
               state_in = ST_CHK;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (high_ff) begin
                  rsp_frac_in   = '0;
                  rsp_reload_in = '0;
                  rsp_err_in    = '0;
                  rsp_status_in = STATUS_RATE_HIGH;
               end else if (!found_ff) begin
                  rsp_frac_in   = '0;
                  rsp_reload_in = '0;
                  rsp_err_in    = ERR_LIMIT;
                  rsp_status_in = STATUS_NO_PAIR;
               end else begin
                  rsp_frac_in   = best_fdv_ff;
                  rsp_reload_in = best_reload_ff;
                  rsp_err_in    = best_err_ff;
                  rsp_status_in = STATUS_OK;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clk_ff       <= CLK_W'(100000000);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clk_ff       <= clk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      target_ff      <= target_in;
      n_ff           <= n_in;
      den_ff         <= den_in;
      bg_ff          <= bg_in;
      rem_ff         <= rem_in;
      sh_ff          <= sh_in;
      q_ff           <= q_in;
      cnt_ff         <= cnt_in;
      fdv_ff         <= fdv_in;
      prod_ff        <= prod_in;
      best_err_ff    <= best_err_in;
      best_fdv_ff    <= best_fdv_in;
      best_reload_ff <= best_reload_in;
      found_ff       <= found_in;
      high_ff        <= high_in;
      rsp_frac_ff    <= rsp_frac_in;
      rsp_reload_ff  <= rsp_reload_in;
      rsp_err_ff     <= rsp_err_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_divider_fraction = rsp_frac_ff;
   assign rsp_reload_value     = rsp_reload_ff;
   assign rsp_rate_error       = rsp_err_ff;
   assign rsp_status           = rsp_status_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_div2_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV2) |-> (rem_ff < DW'(den_ff)))
      else $error("rate division remainder not below divisor");

   a_fdv_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ERR) |-> (fdv_ff <= QW'(FRACTION_FULL_SCALE)))
      else $error("error evaluated for fdv above full scale");

   a_bg_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHK) |-> ((bg_ff != '0) && (bg_ff <= BGW'(MAX_RELOAD_STEPS))))
      else $error("trial divisor out of range");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish state");

   a_ok_error_below_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_OK)) |-> (rsp_err_ff != ERR_LIMIT))
      else $error("ok status with error at limit");

endmodule

/* dv/tb_top.sv */
// tb_top: self-checking bench for fractional_baud_divisor_search; needs fbdiv_pkg and its RTL.
// Checks each response against a typed table result or a local divisor search.
`timescale 1ns / 100ps

module tb_top
   import fbdiv_pkg::*;
();

   // must match the DUT parameters below
   localparam int MAX_RELOAD_STEPS    = 8192;
   localparam int FRACTION_FULL_SCALE = 512;
   localparam int FRAC_W              = $clog2(FRACTION_FULL_SCALE);
   localparam int RELOAD_W            = $clog2(MAX_RELOAD_STEPS);

   // baud generator oversamples each bit by 16
   localparam longint unsigned OVERSAMPLE = 16;
   localparam logic [BAUD_W-1:0] BAUD_MAX  = '1;
   localparam logic [CLK_W-1:0]  CLOCK_MAX = '1;
   localparam logic [CLK_W-1:0]  CLOCK_MIN = 32'd16;
   localparam logic [CLK_W-1:0]  CLOCK_RESET_HZ = 32'd100_000_000;

   // random part: four idle phases, one slow request (rate near clock/16) per phase
   localparam int PHASES           = 4;
   localparam int RANDOM_PER_PHASE = 25;
   localparam int SLOW_SLOT        = 12;
   // cycles to wait after the last response before touching the clock register / ending
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 8;
   // worst request: every trial run in full, padded for gaps and stalls;
   // the limit covers every request taking that long, several times over
   localparam longint unsigned REQUEST_CYCLE_BOUND = 2 + 53 * MAX_RELOAD_STEPS + 500;
   localparam longint unsigned CYCLE_LIMIT = 4 * REQUEST_CYCLE_BOUND * 130;

   typedef struct packed {
      logic [FRAC_W-1:0]   fraction;
      logic [RELOAD_W-1:0] reload;
      logic [ERR_W-1:0]    error;
      status_type          status;
   } divisor_pick_type;

   typedef enum logic [1:0] {
      ROW_SET_CLOCK,
      ROW_TYPED,
      ROW_PREDICTED
   } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [CLK_W-1:0]  clock_hz;
      logic [BAUD_W-1:0] baud;
      divisor_pick_type  result;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 17;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CLK_W-1:0]      csr_wr_data;
   logic                  req_valid;
   logic                  req_stall;
   logic [BAUD_W-1:0]     req_baud_rate;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [FRAC_W-1:0]     rsp_divider_fraction;
   logic [RELOAD_W-1:0]   rsp_reload_value;
   logic [ERR_W-1:0]      rsp_rate_error;
   logic [STATUS_W-1:0]   rsp_status;

   // expected responses in request order, and the bench's copy of the clock register
   divisor_pick_type pending_picks[$];
   divisor_pick_type oldest_pick;
   logic [CLK_W-1:0] clock_hz_shadow;

   int               mismatch_count;
   longint unsigned  cycle_count;
   int               send_idle_pct;
   int               stall_pct;

   // Directed table. Typed rows carry results that follow directly from the rules:
   // zero rate, rate at or above clock/16, and exact hits at the first reload on a
   // clock that is a multiple of 8192 (fraction = rate / (clock/8192), no error).
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // reset clock, 100 MHz
      '{ROW_TYPED,     32'd0,           28'd0,         '{9'd0, 13'd0, 32'd0, STATUS_OK}},
      '{ROW_TYPED,     32'd0,           BAUD_MAX,      '{9'd0, 13'd0, 32'd0, STATUS_RATE_HIGH}},
      '{ROW_TYPED,     32'd0,           28'd6250000,   '{9'd0, 13'd0, 32'd0, STATUS_RATE_HIGH}},
      // one below clock/16: fraction rounds to full scale, encoded as zero
      '{ROW_PREDICTED, 32'd0,           28'd6249999,   '0},
      '{ROW_PREDICTED, 32'd0,           28'd115200,    '0},
      // 8192 * 1000: exact pairs at reload 0
      '{ROW_SET_CLOCK, 32'd8192000,     28'd0,         '0},
      '{ROW_TYPED,     32'd0,           28'd1000,      '{9'd1, 13'd0, 32'd0, STATUS_OK}},
      '{ROW_TYPED,     32'd0,           28'd255000,    '{9'd255, 13'd0, 32'd0, STATUS_OK}},
      '{ROW_TYPED,     32'd0,           28'd511000,    '{9'd511, 13'd0, 32'd0, STATUS_OK}},
      '{ROW_TYPED,     32'd0,           28'd512000,    '{9'd0, 13'd0, 32'd0, STATUS_RATE_HIGH}},
      // slowest legal clock: only a zero rate is below clock/16
      '{ROW_SET_CLOCK, CLOCK_MIN,       28'd0,         '0},
      '{ROW_TYPED,     32'd0,           28'd0,         '{9'd0, 13'd0, 32'd0, STATUS_OK}},
      '{ROW_TYPED,     32'd0,           28'd1,         '{9'd0, 13'd0, 32'd0, STATUS_RATE_HIGH}},
      // fastest clock: clock/16 equals the largest rate field value
      '{ROW_SET_CLOCK, CLOCK_MAX,       28'd0,         '0},
      '{ROW_TYPED,     32'd0,           BAUD_MAX,      '{9'd0, 13'd0, 32'd0, STATUS_RATE_HIGH}},
      '{ROW_TYPED,     32'd0,           28'd0,         '{9'd0, 13'd0, 32'd0, STATUS_OK}},
      '{ROW_SET_CLOCK, CLOCK_RESET_HZ,  28'd0,         '0}
   };

   fractional_baud_divisor_search #(
      .MAX_RELOAD_STEPS    (MAX_RELOAD_STEPS),
      .FRACTION_FULL_SCALE (FRACTION_FULL_SCALE)
   ) DUT (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_baud_rate        (req_baud_rate),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_divider_fraction (rsp_divider_fraction),
      .rsp_reload_value     (rsp_reload_value),
      .rsp_rate_error       (rsp_rate_error),
      .rsp_status           (rsp_status)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sweep trial divisors 1..MAX_RELOAD_STEPS (reload one less); keep the first pair with the
   // strictly smallest error, stop once that error is zero. 64 bits hold every product here.
   function automatic divisor_pick_type best_divisor(input logic [BAUD_W-1:0] baud,
                                                     input logic [CLK_W-1:0] clk_hz);
      longint unsigned  rate, clk, step, target, best_err, fdv, achieved, err, bg;
      bit               found;
      divisor_pick_type pick;
      rate     = baud;
      clk      = clk_hz;
      step     = rate * OVERSAMPLE * FRACTION_FULL_SCALE;
      target   = rate * RATE_SCALE;
      best_err = ERR_LIMIT;
      found    = 1'b0;
      pick     = '0;
      if (rate >= (clk >> 4)) begin
         pick.status = STATUS_RATE_HIGH;
         return pick;
      end
      for (bg = 1; bg <= MAX_RELOAD_STEPS; bg++) begin
         fdv = (step * bg + clk / 2) / clk;
         if (fdv <= FRACTION_FULL_SCALE) begin
            achieved = (fdv * clk * RATE_SCALE) / (OVERSAMPLE * FRACTION_FULL_SCALE * bg);
            err = (achieved < target) ? target - achieved : achieved - target;
            if (err < best_err) begin
               best_err      = err;
               pick.fraction = fdv[FRAC_W-1:0];
               pick.reload   = RELOAD_W'(bg - 1);
               found         = 1'b1;
            end
            if (found && best_err == 0) break;
         end
      end
      if (!found) begin
         pick.error  = ERR_LIMIT;
         pick.status = STATUS_NO_PAIR;
      end else begin
         pick.error  = best_err[ERR_W-1:0];
         pick.status = STATUS_OK;
      end
      return pick;
   endfunction

   // Random rate for one slot. Most requests end fast: an exact pair at reload 0 (clock a
   // multiple of 8192), a rate at or above clock/16, or a zero rate. The slow slot picks a
   // rate in [clock/32, clock/16), which leaves only the first trials inside full scale.
   function automatic logic [BAUD_W-1:0] pick_rate(input int slot, input logic [CLK_W-1:0] hz);
      logic [CLK_W-1:0] ceiling;
      int unsigned      roll;
      ceiling = hz >> 4;
      roll    = $urandom_range(99);
      if (slot == SLOW_SLOT)
         return BAUD_W'($urandom_range(ceiling - 1, hz >> 5));
      if (roll < 60 && hz % 8192 == 0)
         return BAUD_W'((hz / 8192) * $urandom_range(FRACTION_FULL_SCALE - 1, 0));
      if (roll < 90)
         return BAUD_W'($urandom_range(BAUD_MAX, ceiling));
      return '0;
   endfunction

   task automatic check_field(input string field, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Present one request, hold it until accepted, then queue its expected response.
   // valid drops only in a send gap, a clock write or the drain: no step sees two assignments.
   task automatic send_request(input logic [BAUD_W-1:0] baud, input divisor_pick_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_baud_rate <= baud;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_picks.push_back(want);
   endtask

   // Clock register writes only with the block idle: all responses back, then a pause.
   task automatic set_module_clock(input logic [CLK_W-1:0] hz);
      req_valid <= 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= hz;
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      clock_hz_shadow = hz;
   endtask

   // Response side: check whatever was accepted at this edge, then pick the next stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_picks.size() == 0) begin
               $display("%0t ns: response with no request waiting, expected none actual status %0d",
                        $time, rsp_status);
               mismatch_count++;
            end else begin
               oldest_pick = pending_picks.pop_front();
               check_field("divider_fraction", oldest_pick.fraction, rsp_divider_fraction);
               check_field("reload_value", oldest_pick.reload, rsp_reload_value);
               check_field("rate_error", oldest_pick.error, rsp_rate_error);
               check_field("status", oldest_pick.status, rsp_status);
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog on a free-running cycle count.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int               row;
      int               phase;
      int               slot;
      logic [BAUD_W-1:0] baud;
      logic [CLK_W-1:0]  hz;
      clock           = 1'b0;
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_valid       = 1'b0;
      req_baud_rate   = '0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      clock_hz_shadow = CLOCK_RESET_HZ;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling on either side
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         case (directed_rows[row].kind)
            ROW_SET_CLOCK: begin
               set_module_clock(directed_rows[row].clock_hz);
            end
            ROW_TYPED: begin
               send_request(directed_rows[row].baud, directed_rows[row].result);
            end
            default: begin
               send_request(directed_rows[row].baud,
                            best_divisor(directed_rows[row].baud, clock_hz_shadow));
            end
         endcase
      end

      // random part: each phase gets its own clock setting and idle pattern
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: hz = 8192 * $urandom_range(524287, 1);
            1: hz = CLOCK_MAX;
            2: hz = 8192 * $urandom_range(524287, 1);
            default: hz = CLOCK_MIN;
         endcase
         set_module_clock(hz);
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 64;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 64;
            end
            default: begin
               send_idle_pct = 33;
               stall_pct     = 33;
            end
         endcase
         for (slot = 0; slot < RANDOM_PER_PHASE; slot++) begin
            baud = pick_rate(slot, clock_hz_shadow);
            send_request(baud, best_divisor(baud, clock_hz_shadow));
         end
      end

      // drain: wait out every response, then a few quiet cycles
      req_valid <= 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/fbdiv_pkg.sv
hw/rtl/fbdiv_sub_step.sv
hw/rtl/fractional_baud_divisor_search.sv
dv/tb_top.sv
